/* rtl/lkfr_pkg.sv */
// Package for the LRU-K frame replacer: sizes, command, status and state
// codes, transaction structs and the per-frame entry layout.
// No dependencies.
`default_nettype none

package lkfr_pkg;

	localparam int FRAME_SLOTS = 64;
	localparam int FRAME_W     = $clog2(FRAME_SLOTS);
	localparam int TOTAL_W     = FRAME_W + 1;
	localparam int LIMIT_W     = 7;
	localparam int KCOUNT_W    = 4;
	localparam int STAMP_W     = 64;
	localparam int STATUS_W    = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 7;

	localparam logic [LIMIT_W-1:0]  FRAMES_RESET = LIMIT_W'(64);
	localparam logic [KCOUNT_W-1:0] K_RESET      = KCOUNT_W'(2);

	typedef enum logic [1:0] {
		CMD_ACCESS    = 2'd0,
		CMD_SET_EVICT = 2'd1,
		CMD_REMOVE    = 2'd2,
		CMD_EVICT     = 2'd3
	} cmd_e;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE      = 3'd0,
		STAT_IGNORED   = 3'd1,
		STAT_RANGE     = 3'd2,
		STAT_PINNED    = 3'd3,
		STAT_NO_VICTIM = 3'd4
	} status_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAMES_IN_USE = 1'd0,
		CFG_K_THRESHOLD   = 1'd1
	} cfg_reg_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MODIFY,
		S_SCAN,
		S_DRAIN,
		S_PICK
	} state_e;

	typedef struct packed {
		cmd_e               cmd;
		logic [FRAME_W-1:0] frame_index;
		logic               evictable_flag;
	} req_t;

	typedef struct packed {
		status_e            status;
		logic [FRAME_W-1:0] victim_frame;
		logic [TOTAL_W-1:0] evictable_count;
	} rsp_t;

	typedef struct packed {
		logic [KCOUNT_W-1:0] count;
		logic                evict;
		logic                hist;
		logic [STAMP_W-1:0]  stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* rtl/lkfr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lkfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/lru_k_frame_replacer.sv */
// Top level of the LRU-K frame replacer: control, tracked bits, evict scan.
// Depends on lkfr_pkg and lkfr_ram.
`default_nettype none

// Command-style LRU-K replacer over FRAME_SLOTS frames. A transaction is taken
// when start is high and busy is low; its result is shown on rsp for exactly
// one cycle with done high and cannot be held off by the receiver. Access and
// set evictable read and write back one entry of the frame-state RAM; remove
// reads one entry and clears its tracked bit. Evict reads every entry of that
// RAM once, one per cycle, keeping the oldest evictable stamp of each group,
// then goes through S_DRAIN and S_PICK to its result. Tracked bits are
// flip-flops cleared by reset, so no clearing pass is needed. Configuration
// must only be written while the block is idle.
module lru_k_frame_replacer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire lkfr_pkg::req_t                 req,
	output logic                                busy,
	output logic                                done,
	output lkfr_pkg::rsp_t                      rsp,
	input  wire logic                           cfg_we,
	input  wire logic [lkfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lkfr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int FW = lkfr_pkg::FRAME_W;
	localparam int TW = lkfr_pkg::TOTAL_W;
	localparam int KW = lkfr_pkg::KCOUNT_W;
	localparam int SW = lkfr_pkg::STAMP_W;
	localparam int LW = lkfr_pkg::LIMIT_W;

	lkfr_pkg::state_e state_q, state_d;

	logic [LW-1:0]                    frames_q;
	logic [KW-1:0]                    k_q;
	logic [lkfr_pkg::FRAME_SLOTS-1:0] tracked_q;
	logic [SW-1:0]                    ctr_q;
	logic [TW-1:0]                    total_q;
	lkfr_pkg::req_t                   req_q;
	logic                             done_q;
	lkfr_pkg::rsp_t                   rsp_q;

	logic [FW-1:0] scan_q;
	logic          vld_s1;
	logic [FW-1:0] idx_s1;
	logic          hfound_q, cfound_q;
	logic [FW-1:0] hidx_q, cidx_q;
	logic [SW-1:0] hstamp_q, cstamp_q;

	logic                 ram_we, ram_re;
	logic [FW-1:0]        ram_raddr;
	lkfr_pkg::entry_t     ram_wdata, ram_rdata;

	logic                 accept;
	logic [LW-1:0]        limit;
	logic                 in_range;
	logic                 trk;
	logic [KW-1:0]        c0, c1;
	logic                 to_cache;
	logic [1:0]           ctr_inc;
	logic                 set_trk, clr_trk;
	logic [FW-1:0]        clr_idx;
	logic [TW-1:0]        total_d;
	logic [SW-1:0]        ctr_d;
	lkfr_pkg::rsp_t       rsp_d;
	logic                 last_scan;

	logic                 elig, take, have;
	logic [SW-1:0]        bstamp;

	assign accept    = start && !busy;
	assign busy      = (state_q != lkfr_pkg::S_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign limit     = (frames_q < LW'(lkfr_pkg::FRAME_SLOTS)) ? frames_q
	                   : LW'(lkfr_pkg::FRAME_SLOTS);
	assign in_range  = (LW'(req_q.frame_index) < limit);
	assign trk       = tracked_q[req_q.frame_index];
	assign last_scan = (scan_q == FW'(lkfr_pkg::FRAME_SLOTS - 1));

	lkfr_ram #(
		.WIDTH (lkfr_pkg::ENTRY_W),
		.DEPTH (lkfr_pkg::FRAME_SLOTS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req_q.frame_index),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lkfr_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (req.cmd == lkfr_pkg::CMD_EVICT) ? lkfr_pkg::S_SCAN
					          : lkfr_pkg::S_MODIFY;
				end
			end
			lkfr_pkg::S_MODIFY: state_d = lkfr_pkg::S_IDLE;
			lkfr_pkg::S_SCAN: begin
				if (last_scan) begin
					state_d = lkfr_pkg::S_DRAIN;
				end
			end
			lkfr_pkg::S_DRAIN: state_d = lkfr_pkg::S_PICK;
			lkfr_pkg::S_PICK:  state_d = lkfr_pkg::S_IDLE;
			default:           state_d = lkfr_pkg::S_IDLE;
		endcase
	end

	// access count and stamp update
	always_comb begin
		c0       = trk ? ram_rdata.count : '0;
		c1       = (c0 < k_q) ? c0 + KW'(1) : c0;
		to_cache = (c1 >= k_q);
		ctr_inc  = {1'b0, !trk} + {1'b0, to_cache};
	end

	// RAM control and results
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = req.frame_index;
		ram_we    = 1'b0;
		ram_wdata = ram_rdata;
		set_trk   = 1'b0;
		clr_trk   = 1'b0;
		clr_idx   = req_q.frame_index;
		total_d   = total_q;
		ctr_d     = ctr_q;
		rsp_d     = '{status: lkfr_pkg::STAT_DONE, victim_frame: '0, evictable_count: '0};
		unique case (state_q)
			lkfr_pkg::S_IDLE: begin
				ram_re = accept && (req.cmd != lkfr_pkg::CMD_EVICT);
			end
			lkfr_pkg::S_SCAN: begin
				ram_re    = 1'b1;
				ram_raddr = scan_q;
			end
			lkfr_pkg::S_MODIFY: begin
				if (!in_range) begin
					rsp_d.status = lkfr_pkg::STAT_RANGE;
				end else begin
					unique case (req_q.cmd)
						lkfr_pkg::CMD_ACCESS: begin
							if (!trk && (LW'(total_q) >= limit)) begin
								rsp_d.status = lkfr_pkg::STAT_IGNORED;
							end else begin
								ram_we          = 1'b1;
								set_trk         = 1'b1;
								ram_wdata.count = c1;
								ctr_d           = ctr_q + SW'(ctr_inc);
								if (!trk) begin
									ram_wdata.evict = 1'b0;
									ram_wdata.hist  = 1'b1;
									ram_wdata.stamp = ctr_q;
								end
								if (to_cache) begin
									ram_wdata.hist  = 1'b0;
									ram_wdata.stamp = trk ? ctr_q : ctr_q + SW'(1);
								end
							end
						end
						lkfr_pkg::CMD_SET_EVICT: begin
							if (!trk) begin
								rsp_d.status = lkfr_pkg::STAT_IGNORED;
							end else begin
								ram_we          = 1'b1;
								ram_wdata.evict = req_q.evictable_flag;
								if (ram_rdata.evict && !req_q.evictable_flag
								    && (total_q != '0)) begin
									total_d = total_q - TW'(1);
								end else if (!ram_rdata.evict && req_q.evictable_flag) begin
									total_d = total_q + TW'(1);
								end
							end
						end
						lkfr_pkg::CMD_REMOVE: begin
							if (!trk) begin
								rsp_d.status = lkfr_pkg::STAT_IGNORED;
							end else if (!ram_rdata.evict) begin
								rsp_d.status = lkfr_pkg::STAT_PINNED;
							end else begin
								clr_trk = 1'b1;
								if (total_q != '0) begin
									total_d = total_q - TW'(1);
								end
							end
						end
						default: rsp_d.status = lkfr_pkg::STAT_DONE;
					endcase
				end
			end
			lkfr_pkg::S_PICK: begin
				if (hfound_q || cfound_q) begin
					clr_trk            = 1'b1;
					clr_idx            = hfound_q ? hidx_q : cidx_q;
					rsp_d.victim_frame = clr_idx;
					if (total_q != '0) begin
						total_d = total_q - TW'(1);
					end
				end else begin
					rsp_d.status = lkfr_pkg::STAT_NO_VICTIM;
				end
			end
			default: ram_re = 1'b0;
		endcase
		rsp_d.evictable_count = total_d;
	end

	// evict scan compare, one entry per cycle
	always_comb begin
		elig   = vld_s1 && tracked_q[idx_s1] && ram_rdata.evict;
		have   = ram_rdata.hist ? hfound_q : cfound_q;
		bstamp = ram_rdata.hist ? hstamp_q : cstamp_q;
		take   = elig && (!have || (ram_rdata.stamp < bstamp));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lkfr_pkg::S_IDLE;
			frames_q  <= lkfr_pkg::FRAMES_RESET;
			k_q       <= lkfr_pkg::K_RESET;
			tracked_q <= '0;
			ctr_q     <= '0;
			total_q   <= '0;
			done_q    <= 1'b0;
			vld_s1    <= 1'b0;
			hfound_q  <= 1'b0;
			cfound_q  <= 1'b0;
			scan_q    <= '0;
		end else begin
			state_q <= state_d;
			ctr_q   <= ctr_d;
			total_q <= total_d;
			done_q  <= (state_q == lkfr_pkg::S_MODIFY) || (state_q == lkfr_pkg::S_PICK);
			vld_s1  <= (state_q == lkfr_pkg::S_SCAN);
			if (cfg_we) begin
				unique case (cfg_index)
					lkfr_pkg::CFG_FRAMES_IN_USE: frames_q <= LW'(cfg_data);
					lkfr_pkg::CFG_K_THRESHOLD:   k_q      <= KW'(cfg_data);
					default:                     k_q      <= k_q;
				endcase
			end
			if (set_trk) begin
				tracked_q[req_q.frame_index] <= 1'b1;
			end
			if (clr_trk) begin
				tracked_q[clr_idx] <= 1'b0;
			end
			if (accept) begin
				scan_q   <= '0;
				hfound_q <= 1'b0;
				cfound_q <= 1'b0;
			end else begin
				if (state_q == lkfr_pkg::S_SCAN) begin
					scan_q <= scan_q + FW'(1);
				end
				if (take && ram_rdata.hist) begin
					hfound_q <= 1'b1;
				end
				if (take && !ram_rdata.hist) begin
					cfound_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		idx_s1 <= scan_q;
		rsp_q  <= rsp_d;
		if (take && ram_rdata.hist) begin
			hidx_q   <= idx_s1;
			hstamp_q <= ram_rdata.stamp;
		end
		if (take && !ram_rdata.hist) begin
			cidx_q   <= idx_s1;
			cstamp_q <= ram_rdata.stamp;
		end
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_busy_ends_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_scan_data_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == lkfr_pkg::S_SCAN || state_q == lkfr_pkg::S_DRAIN))
		else $error("scan read data outside of evict scan");

	a_ram_write_in_modify: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == lkfr_pkg::S_MODIFY))
		else $error("state RAM written outside of modify");

endmodule

`default_nettype wire
